FILE: hdl/voxel_ever_free_classifier_unit_defines.svh
// Assertion macros for the voxel ever-free classifier
`ifndef VOXEL_EVER_FREE_CLASSIFIER_UNIT_DEFINES_SVH
`define VOXEL_EVER_FREE_CLASSIFIER_UNIT_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define VEF_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("label failed");
// implication whose consequent is checked in the cycle after the antecedent
`define VEF_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("label failed");
`endif

FILE: hdl/vefc_pkg.sv
// Package: types and constants for the voxel ever-free classifier
package vefc_pkg;
   localparam int BLOCK_SIDE_DEF = 8;
   localparam int GRID_SIDE_DEF  = 32;
   localparam int FRAME_BITS_DEF = 24;
   localparam int COORD_W        = 5;
   localparam int ACTION_W       = 3;
   localparam int WEIGHT_W       = 16;
   localparam int OCC_W          = 16;
   localparam int CFG_W          = 8;
   localparam int NEWLY_W        = 10;
   localparam logic [ACTION_W-1:0] ACT_WRITE  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_SWEEP  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_OCC    = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;
   localparam logic CSR_FREE_WINDOW  = 1'b0;
   localparam logic CSR_OCCUPIED_GAP = 1'b1;
   function automatic logic [1:0] off_x(input logic [4:0] k);
      logic [1:0] r;
      r = '0;
      for (int i = 0; i < 27; i++)
         if (k == 5'(i)) r = 2'(i / 9);
      return r;
   endfunction
   function automatic logic [1:0] off_y(input logic [4:0] k);
      logic [1:0] r;
      r = '0;
      for (int i = 0; i < 27; i++)
         if (k == 5'(i)) r = 2'((i / 3) % 3);
      return r;
   endfunction
   function automatic logic [1:0] off_z(input logic [4:0] k);
      logic [1:0] r;
      r = '0;
      for (int i = 0; i < 27; i++)
         if (k == 5'(i)) r = 2'(i % 3);
      return r;
   endfunction
   // offset k (0..26) -> neighbour when one or two axes are nonzero
   function automatic logic is_nbr(input logic [4:0] k);
      int nz;
      nz = int'(off_x(k) != 2'd1) + int'(off_y(k) != 2'd1) + int'(off_z(k) != 2'd1);
      return (nz == 1) || (nz == 2);
   endfunction
endpackage

FILE: hdl/vefc_ram.sv
// Generic single-port RAM with registered read
module vefc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule

FILE: hdl/voxel_ever_free_classifier_unit.sv
// Write, occupancy and read each touch one voxel; remove visits the voxel and its in-grid
// neighbours; a sweep makes up to 19 serial reads per voxel of the block on the one voxel
// memory port. One transaction at a time; req_stall high while one is in progress.
// After reset a clearing pass zeroes every voxel, with req_stall high; csr writes are
// taken at any time.
// Synchronous active-high reset clears control state and loads csr defaults.
module voxel_ever_free_classifier_unit #(
   parameter int BLOCK_SIDE = vefc_pkg::BLOCK_SIDE_DEF,
   parameter int GRID_SIDE  = vefc_pkg::GRID_SIDE_DEF,
   parameter int FRAME_BITS = vefc_pkg::FRAME_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [vefc_pkg::ACTION_W-1:0]   req_action,
   input  logic [vefc_pkg::COORD_W-1:0]    req_voxel_x,
   input  logic [vefc_pkg::COORD_W-1:0]    req_voxel_y,
   input  logic [vefc_pkg::COORD_W-1:0]    req_voxel_z,
   input  logic [FRAME_BITS-1:0]           req_frame_now,
   input  logic [vefc_pkg::WEIGHT_W-1:0]   req_new_weight,
   input  logic [FRAME_BITS-1:0]           req_new_last_occupied,
   input  logic                            req_new_moving,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_index,
   input  logic [vefc_pkg::CFG_W-1:0]      csr_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_out_observed,
   output logic                            rsp_out_ever_free,
   output logic                            rsp_out_moving,
   output logic [FRAME_BITS-1:0]           rsp_out_last_occupied,
   output logic [vefc_pkg::OCC_W-1:0]      rsp_out_occ_count,
   output logic [vefc_pkg::NEWLY_W-1:0]    rsp_newly_free_count
);
   import vefc_pkg::*;
   `include "voxel_ever_free_classifier_unit_defines.svh"

   localparam int CW     = $clog2(GRID_SIDE);
   localparam int AW     = 3 * CW;
   localparam int DEPTH  = 2 ** AW;
   localparam int VW     = 3 + FRAME_BITS + OCC_W;
   localparam int BW     = $clog2(BLOCK_SIDE);
   localparam int BCNT   = BLOCK_SIDE * BLOCK_SIDE * BLOCK_SIDE;
   localparam int BIW    = $clog2(BCNT);
   localparam int SW     = ((CW > COORD_W) ? CW : COORD_W) + 2;

   localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_RDW = 4'd3,
      S_MOD = 4'd4, S_FIN = 4'd5, S_FINW = 4'd6, S_OUT = 4'd7, S_CEN = 4'd8,
      S_CENW = 4'd9, S_NB = 4'd10, S_NBW = 4'd11, S_SET = 4'd12, S_RMV = 4'd13,
      S_RMVW = 4'd14, S_RMWR = 4'd15;

   logic [3:0] state_ff, state_in;
   logic [CFG_W-1:0] win_ff, gap_ff;
   logic [ACTION_W-1:0] act_ff;
   logic [SW-1:0] x_ff, y_ff, z_ff;
   logic [FRAME_BITS-1:0] now_ff, nlast_ff;
   logic nobs_ff, nmov_ff;
   logic [AW:0] clr_ff, clr_in;
   logic [BIW:0] bidx_ff, bidx_in;
   logic [4:0] k_ff, k_in;
   logic ok_ff, ok_in;
   logic [NEWLY_W-1:0] cnt_ff, cnt_in;
   logic [VW-1:0] cur_ff, cur_in;
   logic rv_ff, rv_in;
   logic [VW-1:0] ro_ff, ro_in;
   logic [NEWLY_W-1:0] rn_ff, rn_in;

   logic we;
   logic [AW-1:0] addr;
   logic [VW-1:0] wdata, rdata;

   // voxel word: {observed, free mark, moving, last_occupied, occ_count}
   vefc_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(we), .addr(addr), .wr_data(wdata), .rd_data(rdata));

   logic [SW-1:0] cx, cy, cz, px, py, pz;
   logic sweeping;
   logic in_grid_p, in_grid_c, recent;
   logic signed [FRAME_BITS+1:0] thr;
   logic [CFG_W-1:0] wsel;
   logic [VW-1:0] mod_v;

   always_comb begin
      sweeping = (state_ff == S_CEN) || (state_ff == S_CENW) || (state_ff == S_NB) ||
         (state_ff == S_NBW) || (state_ff == S_SET);
      if (sweeping) begin
         cx = (x_ff & ~SW'(BLOCK_SIDE-1)) + SW'(bidx_ff[3*BW-1 -: BW]);
         cy = (y_ff & ~SW'(BLOCK_SIDE-1)) + SW'(bidx_ff[2*BW-1 -: BW]);
         cz = (z_ff & ~SW'(BLOCK_SIDE-1)) + SW'(bidx_ff[BW-1:0]);
      end else begin
         cx = x_ff; cy = y_ff; cz = z_ff;
      end
      px = cx + SW'(off_x(k_ff)) - SW'(1);
      py = cy + SW'(off_y(k_ff)) - SW'(1);
      pz = cz + SW'(off_z(k_ff)) - SW'(1);
      in_grid_p = (px < SW'(GRID_SIDE)) && (py < SW'(GRID_SIDE)) && (pz < SW'(GRID_SIDE));
      in_grid_c = (cx < SW'(GRID_SIDE)) && (cy < SW'(GRID_SIDE)) && (cz < SW'(GRID_SIDE));
      wsel = (act_ff == ACT_OCC) ? gap_ff : win_ff;
      thr = $signed({2'b00, now_ff}) - $signed({{(FRAME_BITS+2-CFG_W){1'b0}}, wsel});
      recent = $signed({2'b00, rdata[OCC_W +: FRAME_BITS]}) > thr;
      mod_v = rdata;
      unique case (act_ff)
         ACT_WRITE: begin
            mod_v[VW-1] = nobs_ff;
            mod_v[VW-3] = nmov_ff;
            mod_v[OCC_W +: FRAME_BITS] = nlast_ff;
         end
         ACT_OCC: begin
            if (rdata[OCC_W +: FRAME_BITS] != now_ff) begin
               if (recent) begin
                  if (rdata[OCC_W-1:0] != {OCC_W{1'b1}})
                     mod_v[OCC_W-1:0] = rdata[OCC_W-1:0] + OCC_W'(1);
               end else begin
                  mod_v[OCC_W-1:0] = '0;
               end
            end
         end
         default: mod_v = rdata;
      endcase
   end

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; bidx_in = bidx_ff; k_in = k_ff;
      ok_in = ok_ff; cnt_in = cnt_ff; cur_in = cur_ff;
      rv_in = rv_ff; ro_in = ro_ff; rn_in = rn_ff;
      we = 1'b0; wdata = '0;
      addr = {cx[CW-1:0], cy[CW-1:0], cz[CW-1:0]};
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            addr = clr_ff[AW-1:0];
            we = 1'b1;
            clr_in = clr_ff + (AW+1)'(1);
            if (clr_ff == (AW+1)'(DEPTH-1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            bidx_in = '0; cnt_in = '0; k_in = '0;
            if (req_valid) begin
               unique case (req_action)
                  ACT_SWEEP:  state_in = S_CEN;
                  ACT_REMOVE: state_in = S_RMV;
                  default:    state_in = S_RD;
               endcase
            end
         end
         S_RD:  state_in = S_RDW;
         S_RDW: state_in = S_MOD;
         S_MOD: begin
            if (in_grid_c && (act_ff == ACT_WRITE || act_ff == ACT_OCC)) begin
               we = 1'b1; wdata = mod_v;
            end
            state_in = S_FIN;
         end
         S_FIN: state_in = S_FINW;
         S_FINW: state_in = S_OUT;
         S_OUT: begin
            if (!rv_ff) begin
               ro_in = in_grid_c ? rdata : '0;
               rn_in = cnt_ff;
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_CEN: state_in = S_CENW;
         S_CENW: begin
            cur_in = rdata; k_in = '0; ok_in = 1'b1;
            if (!in_grid_c || rdata[VW-2] || recent || !rdata[VW-1]) state_in = S_SET;
            else state_in = S_NB;
            if (!in_grid_c || rdata[VW-2] || recent || !rdata[VW-1]) ok_in = 1'b0;
         end
         S_NB: begin
            addr = {px[CW-1:0], py[CW-1:0], pz[CW-1:0]};
            if (k_ff == 5'd27 || !ok_ff) state_in = S_SET;
            else if (!is_nbr(k_ff)) k_in = k_ff + 5'd1;
            else if (!in_grid_p) begin ok_in = 1'b0; state_in = S_SET; end
            else state_in = S_NBW;
         end
         S_NBW: begin
            addr = {px[CW-1:0], py[CW-1:0], pz[CW-1:0]};
            if (!rdata[VW-1] || recent) ok_in = 1'b0;
            k_in = k_ff + 5'd1;
            state_in = S_NB;
         end
         S_SET: begin
            if (ok_ff) begin
               we = 1'b1; wdata = cur_ff; wdata[VW-2] = 1'b1;
               cnt_in = cnt_ff + NEWLY_W'(1);
            end
            ok_in = 1'b0;
            bidx_in = bidx_ff + (BIW+1)'(1);
            if (bidx_ff == (BIW+1)'(BCNT-1)) begin
               bidx_in = '0;
               state_in = S_FIN;
            end else state_in = S_CEN;
         end
         S_RMV: begin
            addr = {px[CW-1:0], py[CW-1:0], pz[CW-1:0]};
            if (k_ff == 5'd27) state_in = S_FIN;
            else if ((is_nbr(k_ff) || k_ff == 5'd13) && in_grid_p) state_in = S_RMVW;
            else k_in = k_ff + 5'd1;
         end
         S_RMVW: begin
            addr = {px[CW-1:0], py[CW-1:0], pz[CW-1:0]};
            state_in = S_RMWR;
         end
         S_RMWR: begin
            addr = {px[CW-1:0], py[CW-1:0], pz[CW-1:0]};
            we = 1'b1; wdata = rdata; wdata[VW-2] = 1'b0; wdata[VW-3] = 1'b0;
            k_in = k_ff + 5'd1;
            state_in = S_RMV;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; rv_ff <= 1'b0;
         win_ff <= CFG_W'(5); gap_ff <= CFG_W'(2);
         bidx_ff <= '0; k_ff <= '0; ok_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; rv_ff <= rv_in;
         bidx_ff <= bidx_in; k_ff <= k_in; ok_ff <= ok_in; cnt_ff <= cnt_in;
         if (csr_valid) begin
            if (csr_index == CSR_FREE_WINDOW) win_ff <= csr_data;
            else gap_ff <= csr_data;
         end
      end
      cur_ff <= cur_in; ro_ff <= ro_in; rn_ff <= rn_in;
      if (state_ff == S_IDLE && req_valid) begin
         act_ff <= req_action;
         x_ff <= SW'(req_voxel_x); y_ff <= SW'(req_voxel_y); z_ff <= SW'(req_voxel_z);
         now_ff <= req_frame_now; nlast_ff <= req_new_last_occupied;
         nobs_ff <= (req_new_weight != '0); nmov_ff <= req_new_moving;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rv_ff;
   assign rsp_out_observed = ro_ff[VW-1];
   assign rsp_out_ever_free = ro_ff[VW-2];
   assign rsp_out_moving = ro_ff[VW-3];
   assign rsp_out_last_occupied = ro_ff[OCC_W +: FRAME_BITS];
   assign rsp_out_occ_count = ro_ff[OCC_W-1:0];
   assign rsp_newly_free_count = rn_ff;

   `VEF_ASSERT_IMP(a_no_write_idle, clock, reset, state_ff == S_IDLE, !we)
   `VEF_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= NEWLY_W'(BCNT))
   `VEF_ASSERT_NEXT(a_accept_busy, clock, reset, state_ff == S_IDLE && req_valid, req_stall)
   `VEF_ASSERT_NEXT(a_rsp_zero_newly, clock, reset,
      state_ff == S_OUT && !rv_ff && act_ff != ACT_SWEEP, rn_ff == '0)
endmodule
